>>> rtl/mrfp_pkg.sv
`timescale 1ns / 1ps

package mrfp_pkg;

	localparam int unsigned FRAME_BYTES_DEF = 8;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] END_MARK    = 8'h6B;
	localparam logic [7:0] OPTION_CODE = 8'h1A;

	localparam logic [3:0] LEN_POSITION = 4'd8;
	localparam logic [3:0] LEN_OPTION   = 4'd5;
	localparam logic [3:0] LEN_SHORT    = 4'd4;

	localparam logic [7:0] MOTOR_ADDRESS_RST = 8'd1;
	localparam logic [7:0] POSITION_CODE_RST = 8'd54;
	localparam logic [7:0] STATUS_CODE_RST   = 8'd58;

	typedef enum logic [1:0] {
		CFG_MOTOR_ADDRESS,
		CFG_POSITION_CODE,
		CFG_STATUS_CODE
	} cfg_index_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_BAD,
		RES_OPTION,
		RES_SHORT,
		RES_POSITION
	} frame_result_t;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_BAD,
		EV_OPTION,
		EV_SHORT,
		EV_POSITION,
		EV_OTHER
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic [7:0]  fn;
		logic        status_hit;
		logic [7:0]  d2;
		logic [31:0] word;
	} event_t;

endpackage

>>> rtl/mrfp_if.sv
`timescale 1ns / 1ps

interface mrfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrfp_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface mrfp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_result;
	logic [7:0]  recent_function;
	logic [7:0]  recent_reply;
	logic [15:0] option_word;
	logic [7:0]  status_byte;
	logic [31:0] position_magnitude;
	logic        position_negative;
	logic        position_fine_units;
	logic [2:0]  valid_flags;
	logic [15:0] good_frame_count;
	logic [15:0] error_frame_count;

	modport source (output valid, output frame_result, output recent_function,
		output recent_reply, output option_word, output status_byte,
		output position_magnitude, output position_negative,
		output position_fine_units, output valid_flags,
		output good_frame_count, output error_frame_count, input ready);
	modport sink (input valid, input frame_result, input recent_function,
		input recent_reply, input option_word, input status_byte,
		input position_magnitude, input position_negative,
		input position_fine_units, input valid_flags,
		input good_frame_count, input error_frame_count, output ready);
endinterface

>>> rtl/mrfp_front.sv
`timescale 1ns / 1ps

module mrfp_front import mrfp_pkg::*; #(
	parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mrfp_rx_if.sink     rx,
	input  logic [7:0]  motor_address,
	input  logic [7:0]  position_code,
	input  logic [7:0]  status_code,
	output logic        ev_valid,
	input  logic        ev_ready,
	output event_t      ev
);

	localparam int unsigned CW = $clog2(FRAME_BYTES);
	localparam int unsigned NW = CW + 1;

	logic [CW-1:0] count_q;
	logic [7:0]    store_q [FRAME_BYTES];

	logic          accept;
	logic          take;
	logic [NW-1:0] cnt_next;
	logic [7:0]    fn;
	logic [3:0]    need;
	logic          finish;
	logic          bad;

	assign ev_valid = rx.valid;
	assign rx.ready = ev_ready;
	assign accept   = rx.valid && ev_ready;

	always_comb begin
		take     = !(count_q == '0 && rx.rx_byte != motor_address);
		cnt_next = NW'(count_q) + NW'(1);
		fn       = (count_q == CW'(1)) ? rx.rx_byte : store_q[1];
		if (fn == position_code) begin
			need = LEN_POSITION;
		end else if (fn == OPTION_CODE) begin
			need = LEN_OPTION;
		end else begin
			need = LEN_SHORT;
		end
		finish = take && count_q != '0 && cnt_next >= NW'(need);
		bad    = store_q[0] != motor_address || rx.rx_byte != END_MARK;

		ev.fn         = fn;
		ev.status_hit = fn == status_code;
		ev.d2         = store_q[2];
		ev.word       = {store_q[3], store_q[4], store_q[5], store_q[6]};
		if (!finish) begin
			ev.kind = EV_NONE;
		end else if (bad) begin
			ev.kind = EV_BAD;
		end else if (fn == OPTION_CODE && cnt_next == NW'(LEN_OPTION)) begin
			ev.kind = EV_OPTION;
		end else if (cnt_next == NW'(LEN_SHORT)) begin
			ev.kind = EV_SHORT;
		end else if (fn == position_code && cnt_next == NW'(LEN_POSITION)) begin
			ev.kind = EV_POSITION;
		end else begin
			ev.kind = EV_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && take) begin
			if (finish || cnt_next == NW'(FRAME_BYTES)) begin
				count_q <= '0;
			end else begin
				count_q <= cnt_next[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && take) begin
			store_q[count_q] <= rx.rx_byte;
		end
	end

endmodule

>>> rtl/mrfp_queue.sv
`timescale 1ns / 1ps

module mrfp_queue import mrfp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  event_t push_ev,
	output logic   pop_valid,
	input  logic   pop_ready,
	output event_t pop_ev
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

	event_t        slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [FW-1:0] fill_q;
	logic          push;
	logic          pop;

	assign push_ready = fill_q != FW'(QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_ev     = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_ev;
		end
	end

endmodule

>>> rtl/mrfp_back.sv
`timescale 1ns / 1ps

module mrfp_back import mrfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ev_valid,
	output logic       ev_ready,
	input  event_t     ev,
	mrfp_res_if.source res
);

	logic          valid_q;
	frame_result_t result_q;
	logic [7:0]    function_q;
	logic [7:0]    reply_q;
	logic [15:0]   options_q;
	logic [7:0]    status_q;
	logic [31:0]   magnitude_q;
	logic          sign_q;
	logic          units_q;
	logic [2:0]    seen_q;
	logic [15:0]   good_q;
	logic [15:0]   error_q;
	logic          pop;

	assign ev_ready = !valid_q || res.ready;
	assign pop      = ev_valid && ev_ready;

	assign res.valid               = valid_q;
	assign res.frame_result        = result_q;
	assign res.recent_function     = function_q;
	assign res.recent_reply        = reply_q;
	assign res.option_word         = options_q;
	assign res.status_byte         = status_q;
	assign res.position_magnitude  = magnitude_q;
	assign res.position_negative   = sign_q;
	assign res.position_fine_units = units_q;
	assign res.valid_flags         = seen_q;
	assign res.good_frame_count    = good_q;
	assign res.error_frame_count   = error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			result_q    <= RES_NONE;
			function_q  <= '0;
			reply_q     <= '0;
			options_q   <= '0;
			status_q    <= '0;
			magnitude_q <= '0;
			sign_q      <= 1'b0;
			units_q     <= 1'b0;
			seen_q      <= '0;
			good_q      <= '0;
			error_q     <= '0;
		end else if (pop) begin
			valid_q <= 1'b1;
			if (ev.kind != EV_NONE && ev.kind != EV_BAD) begin
				function_q <= ev.fn;
				good_q     <= good_q + 16'd1;
			end
			case (ev.kind)
				EV_BAD: begin
					error_q  <= error_q + 16'd1;
					result_q <= RES_BAD;
				end
				EV_OPTION: begin
					options_q <= {ev.d2, ev.word[31:24]};
					seen_q[0] <= 1'b1;
					result_q  <= RES_OPTION;
				end
				EV_SHORT: begin
					reply_q <= ev.d2;
					if (ev.status_hit) begin
						status_q  <= ev.d2;
						seen_q[1] <= 1'b1;
					end
					result_q <= RES_SHORT;
				end
				EV_POSITION: begin
					magnitude_q <= ev.word;
					sign_q      <= ev.d2 != 8'd0;
					units_q     <= seen_q[0] && options_q[1];
					seen_q[2]   <= 1'b1;
					result_q    <= RES_POSITION;
				end
				default: begin
					result_q <= RES_NONE;
				end
			endcase
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/motor_reply_frame_parser.sv
// channel | dir | handshake   | words
// rx      | in  | valid/ready | rx_byte, one received byte
// cfg     | in  | valid/ready | index, data; register write, always ready
// res     | out | valid/ready | frame_result and the whole kept state
//
// One byte a cycle while rx is not stalled; every byte yields one result word.
// The front tracks the frame position and classifies; a two-word queue feeds the back,
// which holds the kept state and the output register.
// rx stalls only when the queue is full; res stalls back into the queue.
// Reset clears the frame position, the kept state and restores the register defaults.
`timescale 1ns / 1ps

module motor_reply_frame_parser import mrfp_pkg::*; #(
	parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mrfp_rx_if.sink    rx,
	mrfp_cfg_if.sink   cfg,
	mrfp_res_if.source res
);

	logic [7:0] motor_address_q;
	logic [7:0] position_code_q;
	logic [7:0] status_code_q;

	logic   front_valid;
	logic   front_ready;
	event_t front_ev;
	logic   back_valid;
	logic   back_ready;
	event_t back_ev;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_address_q <= MOTOR_ADDRESS_RST;
			position_code_q <= POSITION_CODE_RST;
			status_code_q   <= STATUS_CODE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MOTOR_ADDRESS: motor_address_q <= cfg.data;
				CFG_POSITION_CODE: position_code_q <= cfg.data;
				CFG_STATUS_CODE:   status_code_q   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	mrfp_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.motor_address(motor_address_q),
		.position_code(position_code_q),
		.status_code(status_code_q),
		.ev_valid(front_valid),
		.ev_ready(front_ready),
		.ev(front_ev)
	);

	mrfp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_ev(front_ev),
		.pop_valid(back_valid),
		.pop_ready(back_ready),
		.pop_ev(back_ev)
	);

	mrfp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.ev_valid(back_valid),
		.ev_ready(back_ready),
		.ev(back_ev),
		.res(res)
	);

endmodule

>>> tb/sv/mrfp_reply_checker.sv
`timescale 1ns / 1ps

module mrfp_reply_checker import mrfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mrfp_rx_if          rx,
	mrfp_cfg_if         cfg,
	mrfp_res_if         res,
	output int unsigned mismatches,
	output int unsigned pending
);

	typedef struct packed {
		frame_result_t kind;
		logic [7:0]    fn;
		logic [7:0]    reply;
		logic [15:0]   options;
		logic [7:0]    status;
		logic [31:0]   magnitude;
		logic          negative;
		logic          units;
		logic [2:0]    seen;
		logic [15:0]   good;
		logic [15:0]   bad;
	} parser_view_t;

	int unsigned  mismatch_count;
	int unsigned  wait_count;

	logic [7:0]   addr_reg;
	logic [7:0]   poscode_reg;
	logic [7:0]   statcode_reg;

	logic [7:0]   frame_buf [FRAME_BYTES_DEF];
	logic [3:0]   fill;
	logic [7:0]   held_fn;
	logic [7:0]   held_reply;
	logic [15:0]  held_options;
	logic [7:0]   held_status;
	logic [31:0]  held_mag;
	logic         held_neg;
	logic         held_units;
	logic [2:0]   seen;
	logic [15:0]  good_cnt;
	logic [15:0]  bad_cnt;

	parser_view_t expected_views [$];

	assign mismatches = mismatch_count;
	assign pending    = wait_count;

	function automatic frame_result_t close_frame(input logic [3:0] len);
		logic [7:0] fn;
		fn = frame_buf[1];
		if (frame_buf[0] != addr_reg || frame_buf[3'(len - 4'd1)] != END_MARK) begin
			bad_cnt = bad_cnt + 16'd1;
			return RES_BAD;
		end
		held_fn  = fn;
		good_cnt = good_cnt + 16'd1;
		if (fn == OPTION_CODE && len == LEN_OPTION) begin
			held_options = {frame_buf[2], frame_buf[3]};
			seen[0] = 1'b1;
			return RES_OPTION;
		end
		if (len == LEN_SHORT) begin
			held_reply = frame_buf[2];
			if (fn == statcode_reg) begin
				held_status = frame_buf[2];
				seen[1] = 1'b1;
			end
			return RES_SHORT;
		end
		if (fn == poscode_reg && len == LEN_POSITION) begin
			held_mag   = {frame_buf[3], frame_buf[4], frame_buf[5], frame_buf[6]};
			held_neg   = (frame_buf[2] != 8'd0);
			held_units = seen[0] && held_options[1];
			seen[2] = 1'b1;
			return RES_POSITION;
		end
		return RES_NONE;
	endfunction

	function automatic parser_view_t parse_byte(input logic [7:0] b);
		logic [3:0]   need;
		parser_view_t v;
		v.kind = RES_NONE;
		if (fill >= FRAME_BYTES_DEF)
			fill = 4'd0;
		// hunting: anything but the address is dropped
		if (!(fill == 4'd0 && b != addr_reg)) begin
			frame_buf[fill[2:0]] = b;
			fill = fill + 4'd1;
			if (fill >= 4'd2) begin
				need = (frame_buf[1] == poscode_reg) ? LEN_POSITION :
					(frame_buf[1] == OPTION_CODE) ? LEN_OPTION : LEN_SHORT;
				if (fill >= need) begin
					v.kind = close_frame(fill);
					fill = 4'd0;
				end
			end
		end
		v.fn        = held_fn;
		v.reply     = held_reply;
		v.options   = held_options;
		v.status    = held_status;
		v.magnitude = held_mag;
		v.negative  = held_neg;
		v.units     = held_units;
		v.seen      = seen;
		v.good      = good_cnt;
		v.bad       = bad_cnt;
		return v;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			if (mismatch_count < 10)
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		parser_view_t want;
		if (!arst_n) begin
			addr_reg     = MOTOR_ADDRESS_RST;
			poscode_reg  = POSITION_CODE_RST;
			statcode_reg = STATUS_CODE_RST;
			foreach (frame_buf[i])
				frame_buf[i] = 8'd0;
			fill         = 4'd0;
			held_fn      = 8'd0;
			held_reply   = 8'd0;
			held_options = 16'd0;
			held_status  = 8'd0;
			held_mag     = 32'd0;
			held_neg     = 1'b0;
			held_units   = 1'b0;
			seen         = 3'd0;
			good_cnt     = 16'd0;
			bad_cnt      = 16'd0;
			expected_views.delete();
			wait_count = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_views.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result word with nothing expected", $time);
					mismatch_count++;
				end else begin
					want = expected_views.pop_front();
					check_field("frame_result", want.kind, res.frame_result);
					check_field("recent_function", want.fn, res.recent_function);
					check_field("recent_reply", want.reply, res.recent_reply);
					check_field("option_word", want.options, res.option_word);
					check_field("status_byte", want.status, res.status_byte);
					check_field("position_magnitude", want.magnitude,
						res.position_magnitude);
					check_field("position_negative", want.negative, res.position_negative);
					check_field("position_fine_units", want.units,
						res.position_fine_units);
					check_field("valid_flags", want.seen, res.valid_flags);
					check_field("good_frame_count", want.good, res.good_frame_count);
					check_field("error_frame_count", want.bad, res.error_frame_count);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg_index_t'(cfg.index))
					CFG_MOTOR_ADDRESS: addr_reg = cfg.data;
					CFG_POSITION_CODE: poscode_reg = cfg.data;
					CFG_STATUS_CODE: statcode_reg = cfg.data;
					default: ;
				endcase
			end
			if (rx.valid && rx.ready)
				expected_views.push_back(parse_byte(rx.rx_byte));
			wait_count = expected_views.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import mrfp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        quiet_run;
	int unsigned hold_requests;
	int unsigned mismatches;
	int unsigned pending;
	int unsigned frame_bytes_sent;
	logic [7:0]  addr_now;
	logic [7:0]  poscode_now;
	logic [7:0]  statcode_now;
	logic [7:0]  frame_q [$];

	mrfp_rx_if  rx_ch ();
	mrfp_cfg_if cfg_ch ();
	mrfp_res_if res_ch ();

	motor_reply_frame_parser uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.cfg    (cfg_ch),
		.res    (res_ch)
	);

	mrfp_reply_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.cfg        (cfg_ch),
		.res        (res_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = quiet_run ? 0 : $urandom_range(0, 3);
		cfg_ch.valid <= 1'b0;
		if (gap != 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_queue();
		foreach (frame_q[i])
			send_byte(frame_q[i]);
		frame_bytes_sent += frame_q.size();
		frame_q.delete();
	endtask

	// only once every result word is back
	task automatic write_reg(input cfg_index_t idx, input logic [7:0] v);
		rx_ch.valid  <= 1'b0;
		cfg_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		case (idx)
			CFG_MOTOR_ADDRESS: addr_now = v;
			CFG_POSITION_CODE: poscode_now = v;
			CFG_STATUS_CODE: statcode_now = v;
			default: ;
		endcase
	endtask

	initial begin : result_side
		int unsigned stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = quiet_run ? 0 : $urandom_range(0, 3);
			if (hold_requests != 0) begin
				hold_requests--;
				stall = 80;
			end
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int unsigned phase;
		int unsigned kind;
		int unsigned len;
		int unsigned target;
		int unsigned guard;
		logic [7:0]  fn;
		logic [7:0]  rnd;
		arst_n           = 1'b0;
		quiet_run        = 1'b0;
		hold_requests    = 0;
		frame_bytes_sent = 0;
		rx_ch.valid      = 1'b0;
		rx_ch.rx_byte    = 8'd0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = CFG_MOTOR_ADDRESS;
		cfg_ch.data      = 8'd0;
		addr_now         = MOTOR_ADDRESS_RST;
		poscode_now      = POSITION_CODE_RST;
		statcode_now     = STATUS_CODE_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_byte(8'hFF);
		frame_q = '{8'h01, 8'h3A, 8'h80, END_MARK};
		send_queue();
		frame_q = '{8'h01, OPTION_CODE, 8'h80, 8'h02, END_MARK};
		send_queue();
		frame_q = '{8'h01, 8'h36, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, END_MARK};
		send_queue();
		frame_q = '{8'h01, 8'h05, 8'h7F, 8'h00};
		send_queue();
		// address moved under an open frame
		send_byte(8'h01);
		write_reg(CFG_MOTOR_ADDRESS, 8'h00);
		frame_q = '{OPTION_CODE, 8'h00, 8'h00, END_MARK};
		send_queue();
		// position code moved after the function byte: frame shrinks to four
		frame_q = '{8'h00, 8'h36};
		send_queue();
		write_reg(CFG_POSITION_CODE, OPTION_CODE);
		frame_q = '{8'h00, END_MARK};
		send_queue();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(CFG_MOTOR_ADDRESS, MOTOR_ADDRESS_RST);
					write_reg(CFG_POSITION_CODE, POSITION_CODE_RST);
					write_reg(CFG_STATUS_CODE, STATUS_CODE_RST);
				end
				1: begin
					write_reg(CFG_MOTOR_ADDRESS, 8'hFF);
					write_reg(CFG_POSITION_CODE, 8'h00);
					write_reg(CFG_STATUS_CODE, 8'hFF);
				end
				2: begin
					write_reg(CFG_MOTOR_ADDRESS, 8'h00);
					write_reg(CFG_POSITION_CODE, 8'hFF);
					write_reg(CFG_STATUS_CODE, 8'h00);
				end
				3: begin
					write_reg(CFG_MOTOR_ADDRESS, 8'($urandom_range(1, 255)));
					write_reg(CFG_POSITION_CODE, OPTION_CODE);
					write_reg(CFG_STATUS_CODE, OPTION_CODE);
				end
				4: begin
					write_reg(CFG_MOTOR_ADDRESS, 8'($urandom_range(0, 255)));
					write_reg(CFG_POSITION_CODE, 8'($urandom_range(0, 255)));
					write_reg(CFG_STATUS_CODE, poscode_now);
				end
				default: begin
					write_reg(CFG_MOTOR_ADDRESS, 8'($urandom_range(0, 255)));
					write_reg(CFG_POSITION_CODE, 8'($urandom_range(0, 255)));
					write_reg(CFG_STATUS_CODE, 8'($urandom_range(0, 255)));
				end
			endcase
			quiet_run = (phase == 1);
			if (phase == 2)
				hold_requests = 1;
			target = frame_bytes_sent + 65;
			while (frame_bytes_sent < target) begin
				kind = $urandom_range(0, 9);
				if (kind == 8) begin
					repeat ($urandom_range(1, 3)) begin
						rnd = 8'($urandom);
						send_byte(rnd);
					end
				end else begin
					rnd = 8'($urandom);
					fn = (kind <= 2) ? poscode_now : (kind <= 4) ? OPTION_CODE :
						(kind <= 6) ? statcode_now : rnd;
					len = (fn == poscode_now) ? 8 : (fn == OPTION_CODE) ? 5 : 4;
					// truncated frame: the next frame's bytes run into it
					if (kind == 9)
						len = $urandom_range(1, len - 1);
					frame_q.push_back(addr_now);
					if (len > 1)
						frame_q.push_back(fn);
					for (int i = 2; i < len; i++) begin
						rnd = 8'($urandom);
						frame_q.push_back((i == 2 && $urandom_range(0, 1) == 0) ? 8'h00 : rnd);
					end
					if (kind != 9) begin
						rnd = 8'($urandom);
						frame_q[len - 1] = ($urandom_range(0, 7) == 0) ? rnd : END_MARK;
					end
					send_queue();
				end
			end
		end

		quiet_run = 1'b0;
		rx_ch.valid  <= 1'b0;
		cfg_ch.valid <= 1'b0;
		guard = 0;
		do begin
			@(negedge clk);
			guard++;
		end while (pending != 0 && guard < 2000);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
